// ----- rtl/xorshift_weyl_rng_4096_defines.svh -----
// Assertion macros for the xorshift/Weyl random number generator.
// Used by the port checker; no other dependencies.
`ifndef XORSHIFT_WEYL_RNG_4096_DEFINES_SVH
`define XORSHIFT_WEYL_RNG_4096_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define XWR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define XWR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked during reset.
`define XWR_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/xwr_pkg.sv -----
// Shared types, constants and functions of the xorshift/Weyl generator.
// No dependencies.
`default_nettype none

package xwr_pkg;

    localparam int C_RING_WORDS      = 64;
    localparam int C_IDX_W           = $clog2(C_RING_WORDS);
    localparam int C_WORD_W          = 64;
    localparam int C_LAG             = 53;
    localparam int C_TAP_OFS         = C_RING_WORDS - C_LAG;
    localparam int C_SHIFT_A         = 33;
    localparam int C_SHIFT_B         = 26;
    localparam int C_SHIFT_C         = 27;
    localparam int C_SHIFT_D         = 29;
    localparam int C_SCRAMBLE_ROUNDS = 64;
    localparam int C_DISCARD_STEPS   = 4 * C_RING_WORDS;
    localparam int C_CNT_W           = $clog2(C_DISCARD_STEPS + 1);

    localparam logic [C_WORD_W-1:0] C_WEYL_STEP = 64'h61c8_8646_80b5_83eb;

    localparam logic [C_CNT_W-1:0] C_CNT_SCR_LAST  = C_CNT_W'(C_SCRAMBLE_ROUNDS - 1);
    localparam logic [C_CNT_W-1:0] C_CNT_FILL_LAST = C_CNT_W'(C_RING_WORDS);
    localparam logic [C_CNT_W-1:0] C_CNT_DISC_LAST = C_CNT_W'(C_DISCARD_STEPS - 1);
    localparam logic [C_IDX_W-1:0] C_TAP_OFS_IDX   = C_IDX_W'(C_TAP_OFS);

    typedef logic [C_WORD_W-1:0] t_word;
    typedef logic [C_IDX_W-1:0]  t_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCRAMBLE,
        S_FILL,
        S_DISCARD,
        S_DRAW,
        S_WB,
        S_DONE
    } t_state;

    // One cycle of ring memory access: one write port, two read ports.
    typedef struct packed {
        logic  we;
        t_idx  waddr;
        t_word wdata;
        t_idx  raddr_a;
        t_idx  raddr_b;
    } t_ram_req;

    function automatic t_word f_scramble(input t_word v);
        t_word x;
        x = v ^ (v << 7);
        x = x ^ (x >> 9);
        return x;
    endfunction

    // New ring word from the current word and the lagged word.
    function automatic t_word f_advance(input t_word cur, input t_word lag);
        t_word t;
        t_word v;
        t = cur ^ (cur << C_SHIFT_A);
        t = t ^ (t >> C_SHIFT_B);
        v = lag ^ (lag << C_SHIFT_C);
        v = v ^ t ^ (v >> C_SHIFT_D);
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/xwr_req_if.sv -----
// Request channel of the generator: valid, ready and the seed.
// Depends on xwr_pkg.
`default_nettype none

interface xwr_req_if
    import xwr_pkg::*;
;
    logic  valid;
    logic  ready;
    t_word seed;

    modport source (output valid, output seed, input ready);
    modport sink (input valid, input seed, output ready);
endinterface

`default_nettype wire

// ----- rtl/xwr_rsp_if.sv -----
// Result channel of the generator: valid, ready and the random value.
// Depends on xwr_pkg.
`default_nettype none

interface xwr_rsp_if
    import xwr_pkg::*;
;
    logic  valid;
    logic  ready;
    t_word random_value;

    modport source (output valid, output random_value, input ready);
    modport sink (input valid, input random_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/xwr_ring_ram.sv -----
// Ring word memory: 64 x 64 bits, one write and two registered reads per cycle.
// Depends on xwr_pkg.
`default_nettype none

module xwr_ring_ram
    import xwr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_ram_req i_req,
    output t_word         o_rd_a,
    output t_word         o_rd_b
);

    t_word r_mem [C_RING_WORDS];
    t_word r_rd_a;
    t_word r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_a <= r_mem[i_req.raddr_a];
        r_rd_b <= r_mem[i_req.raddr_b];
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

`default_nettype wire

// ----- rtl/xwr_core.sv -----
// Sequencer and datapath: reseed, ring fill, discard steps and draws.
// Depends on xwr_pkg; drives the ring memory through a t_ram_req.
`default_nettype none

module xwr_core
    import xwr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire t_word i_seed,
    output logic       o_idle,
    output logic       o_res_valid,
    output t_word      o_res_value,
    input  wire logic  i_res_ready,
    output t_ram_req   o_ram_req,
    input  wire t_word i_rd_a,
    input  wire t_word i_rd_b
);

    t_state              r_state, n_state;
    logic [C_CNT_W-1:0]  r_cnt, n_cnt;
    t_idx                r_idx, n_idx;
    t_idx                r_wr_idx;
    logic                r_adv_v;
    logic                r_seeded, n_seeded;
    t_word               r_v, n_v;
    t_word               r_weyl, n_weyl;
    t_word               r_word, n_word;

    logic  issue;
    t_idx  idx_next;
    t_word adv_word;
    logic  need_reseed;

    assign idx_next    = r_idx + 1'b1;
    assign adv_word    = f_advance(i_rd_a, i_rd_b);
    assign need_reseed = !r_seeded || (i_seed != '0);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = need_reseed ? S_SCRAMBLE : S_DRAW;
                end
            end
            S_SCRAMBLE: begin
                if (r_cnt == C_CNT_SCR_LAST) n_state = S_FILL;
            end
            S_FILL: begin
                if (r_cnt == C_CNT_FILL_LAST) n_state = S_DISCARD;
            end
            S_DISCARD: begin
                if (r_cnt == C_CNT_DISC_LAST) n_state = S_DRAW;
            end
            S_DRAW:  n_state = S_WB;
            S_WB:    n_state = S_DONE;
            S_DONE: begin
                if (i_res_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and memory control.
    always_comb begin
        o_idle      = 1'b0;
        o_res_valid = 1'b0;
        issue       = 1'b0;
        o_ram_req   = '{we: 1'b0, waddr: r_wr_idx, wdata: adv_word,
                        raddr_a: idx_next, raddr_b: idx_next + C_TAP_OFS_IDX};
        case (r_state)
            S_IDLE:    o_idle = 1'b1;
            S_FILL: begin
                // Count zero only loads the pipeline; word k is written at count k+1.
                if (r_cnt != '0) begin
                    o_ram_req.we    = 1'b1;
                    o_ram_req.waddr = C_IDX_W'(r_cnt - 1'b1);
                    o_ram_req.wdata = r_v + r_weyl;
                end
            end
            S_DISCARD: issue = 1'b1;
            S_DRAW:    issue = 1'b1;
            S_DONE:    o_res_valid = 1'b1;
            default: begin
            end
        endcase
        if (r_adv_v) begin
            o_ram_req.we = 1'b1;
        end
    end

    assign o_res_value = r_word + r_weyl;

    // Datapath next values.
    always_comb begin
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_v      = r_v;
        n_weyl   = r_weyl;
        n_word   = r_word;
        n_seeded = r_seeded;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                n_v   = (i_seed != '0) ? i_seed : ~i_seed;
            end
            S_SCRAMBLE: begin
                n_v = f_scramble(r_v);
                if (r_cnt == C_CNT_SCR_LAST) begin
                    n_weyl = f_scramble(r_v);
                    n_cnt  = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FILL: begin
                if (r_cnt == C_CNT_FILL_LAST) begin
                    n_cnt    = '0;
                    n_idx    = '1;
                    n_seeded = 1'b1;
                end else begin
                    n_v    = f_scramble(r_v);
                    n_weyl = r_weyl + C_WEYL_STEP;
                    n_cnt  = r_cnt + 1'b1;
                end
            end
            S_DISCARD: begin
                n_idx = idx_next;
                n_cnt = r_cnt + 1'b1;
            end
            S_DRAW: n_idx = idx_next;
            S_WB: begin
                n_word = adv_word;
                n_weyl = r_weyl + C_WEYL_STEP;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_idx    <= '0;
            r_adv_v  <= 1'b0;
            r_seeded <= 1'b0;
            r_weyl   <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_idx    <= n_idx;
            r_adv_v  <= issue;
            r_seeded <= n_seeded;
            r_weyl   <= n_weyl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v      <= n_v;
        r_word   <= n_word;
        r_wr_idx <= idx_next;
    end

endmodule

`default_nettype wire

// ----- rtl/xorshift_weyl_rng_4096.sv -----
// Xorshift/Weyl random number generator over a 64-word ring of 64-bit words.
// Each request returns one 64-bit value. A draw-only request (zero seed, ring
// already seeded) issues the two ring reads, computes and writes back the new
// word, then adds the Weyl sum into the output register; the next request is
// taken once the result sits in the output register. A request with a nonzero
// seed, or the first one after reset, reseeds first: 64 scramble rounds, a fill
// of all 64 ring words and 256 discard steps at one step per cycle through the
// memory's two read ports. Only one request is in work at a time.
// Depends on xwr_pkg, xwr_req_if, xwr_rsp_if, xwr_ring_ram and xwr_core.
`default_nettype none

module xorshift_weyl_rng_4096
    import xwr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    xwr_req_if.sink    i_req,
    xwr_rsp_if.source  o_rsp
);

    t_ram_req ram_req;
    t_word    rd_a;
    t_word    rd_b;
    logic     core_idle;
    logic     res_valid;
    t_word    res_value;
    logic     res_ready;

    logic  r_out_valid;
    t_word r_out_value;

    xwr_ring_ram u_ram (
        .i_clk  (i_clk),
        .i_req  (ram_req),
        .o_rd_a (rd_a),
        .o_rd_b (rd_b)
    );

    xwr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_req.valid),
        .i_seed      (i_req.seed),
        .o_idle      (core_idle),
        .o_res_valid (res_valid),
        .o_res_value (res_value),
        .i_res_ready (res_ready),
        .o_ram_req   (ram_req),
        .i_rd_a      (rd_a),
        .i_rd_b      (rd_b)
    );

    assign i_req.ready = core_idle;

    // The output register frees up as soon as its value is taken.
    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out_value <= res_value;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.random_value = r_out_value;

endmodule

`default_nettype wire

// ----- rtl/xwr_checker.sv -----
// Port-level checks of the generator, bound to the top level.
// Depends on xwr_pkg and the assertion macros header.
`default_nettype none

`include "xorshift_weyl_rng_4096_defines.svh"

module xwr_checker
    import xwr_pkg::*;
(
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    input wire logic  i_req_valid,
    input wire logic  i_req_ready,
    input wire logic  i_rsp_valid,
    input wire logic  i_rsp_ready,
    input wire t_word i_rsp_value
)
;

    // A pending result is not withdrawn before it is taken.
    `XWR_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid, "result withdrawn while stalled")

    // A stalled result keeps its value.
    `XWR_ASSERT_NEXT(a_rsp_stable, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, $stable(i_rsp_value), "result changed while stalled")

    // Only one request is in work: an accepted request closes the input.
    `XWR_ASSERT_NEXT(a_one_in_work, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready, "request taken while another is in work")

    // Nothing can complete in the cycle right after a request is taken.
    `XWR_ASSERT_NEXT(a_min_latency, i_clk, i_rst_n, i_req_valid && i_req_ready, !$rose(i_rsp_valid), "result appeared too soon after request")

    // Reset empties the output register.
    `XWR_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !i_rsp_valid, "result valid after reset")

endmodule

bind xorshift_weyl_rng_4096 xwr_checker u_xwr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_value (o_rsp.random_value)
);

`default_nettype wire
